// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_num;
      logic [62:0]        result_den;
      logic [1:0]         status;
   } rsp_type;

   // operation for the shared divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_G1_DIV,
      S_G1_WAIT,
      S_L_DIV,
      S_L_WAIT,
      S_L_MUL,
      S_TA_DIV,
      S_TA_WAIT,
      S_TA_MUL,
      S_TB_DIV,
      S_TB_WAIT,
      S_TB_MUL,
      S_COMBINE,
      S_MD_MUL1,
      S_MD_MUL2,
      S_G2_DIV,
      S_G2_WAIT,
      S_RN_DIV,
      S_RN_WAIT,
      S_RD_DIV,
      S_RD_WAIT,
      S_FINISH
   } state_type;

endpackage

// ===== hw/rtl/rau_divider.sv =====
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_cmd_type div_cmd,
   output rau_pkg::div_rsp_type div_rsp
);
   import rau_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] shifted;

   // one quotient bit per cycle, restoring
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, dsr_ff};
      if (div_cmd.start) begin
         quo_in  = div_cmd.dividend;
         rem_in  = '0;
         dsr_in  = div_cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
         end else begin
            rem_in = shifted[63:0];
         end
         quo_in = {quo_ff[62:0], ~trial[64]};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !div_cmd.start) |=> !busy_ff) else $error("divider woke");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |=> busy_ff) else $error("divider did not start");

endmodule

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: a/b op c/d with gcd reduction.
//
// Input: pulse start with req carrying command and four operands; the item
// transfers at a clock edge where start is high and busy is low. busy drops
// in the cycle in which rsp_valid is high.
// Output: rsp_valid is high for exactly one cycle with rsp holding the
// reduced fraction and status; the receiver cannot stall, so it must take
// the transfer in that cycle.
// Resources: all division, remainder and gcd work runs on one shared radix-2
// divider; each use issues the operation, runs one bit step per quotient bit
// and takes the result. Multiplies use a single 32x32 multiplier, one
// product per cycle. Add and subtract need one use per Euclid step of
// gcd(den) (at most 45), lcm, two scalings, one use per Euclid step of the
// final gcd (at most 91) and two reductions. Multiply and divide skip the
// first gcd, the lcm and the scalings. Throughput is one item at a time; a
// new start can transfer at the edge that ends the rsp_valid cycle.
// Error results (zero denominator, divide by zero fraction) are decided in
// S_CHECK, the state after the transfer, and registered; overflow is decided
// in S_FINISH after reduction. Both carry num and den zero.
// Reset: synchronous, active high; returns to idle, any item is dropped.
module rational_arithmetic_unit_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   state_type   state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic        aneg_ff, aneg_in, bneg_ff, bneg_in, rneg_ff, rneg_in;
   logic [63:0] x_ff, x_in, y_ff, y_in;     // gcd operands
   logic [63:0] num_ff, num_in, den_ff, den_in;
   logic [63:0] l_ff, l_in, ta_ff, ta_in, q_ff, q_in;
   logic        vld_ff, vld_in;
   rsp_type     rsp_ff, rsp_in;
   div_cmd_type div_cmd;
   div_rsp_type div_rsp;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;

   // sign-extend from OPERAND_WIDTH and take magnitude
   function automatic logic [32:0] take(input logic [31:0] raw);
      logic [31:0] v;
      logic        n;
      logic [32:0] res;
      v = raw << (32 - OPERAND_WIDTH);
      v = $signed(v) >>> (32 - OPERAND_WIDTH);
      n = v[31];
      res = {n, n ? (32'd0 - v) : v};
      return res;
   endfunction

   rau_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_cmd(div_cmd),
      .div_rsp(div_rsp)
   );

   // shared multiplier: 32 x 32 bits; every factor fits in 32 bits
   assign prod = mul_a * mul_b;

   always_comb begin
      logic [32:0] t_an, t_ad, t_bn, t_bd;
      state_in = state_ff;
      cmd_in = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      aneg_in = aneg_ff; bneg_in = bneg_ff; rneg_in = rneg_ff;
      x_in = x_ff; y_in = y_ff;
      num_in = num_ff; den_in = den_ff;
      l_in = l_ff; ta_in = ta_ff; q_in = q_ff;
      vld_in = 1'b0;
      rsp_in = rsp_ff;
      div_cmd = '0;
      mul_a = '0;
      mul_b = '0;
      t_an = take(req_data.a_num);
      t_ad = take(req_data.a_den);
      t_bn = take(req_data.b_num);
      t_bd = take(req_data.b_den);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_data.command;
               an_in = t_an[31:0]; ad_in = t_ad[31:0];
               bn_in = t_bn[31:0]; bd_in = t_bd[31:0];
               aneg_in = (t_an[32] != t_ad[32]) && (t_an[31:0] != '0);
               bneg_in = (t_bn[32] != t_bd[32]) && (t_bn[31:0] != '0);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ad_ff == '0 || bd_ff == '0 ||
                  (cmd_ff == CMD_DIV && bn_ff == '0)) begin
               rsp_in = '{result_num: '0, result_den: '0, status: ST_DIV_ZERO};
               vld_in = 1'b1;
               state_in = S_IDLE;
            end else if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
               if (cmd_ff == CMD_SUB && bn_ff != '0) bneg_in = !bneg_ff;
               x_in = {32'd0, ad_ff};
               y_in = {32'd0, bd_ff};
               state_in = S_G1_DIV;
            end else begin
               rneg_in = aneg_ff != bneg_ff;
               state_in = S_MD_MUL1;
            end
         end
         // Euclid step: x, y <- y, x mod y
         S_G1_DIV, S_G2_DIV: begin
            if (y_ff == '0) begin
               state_in = (state_ff == S_G1_DIV) ? S_L_DIV : S_RN_DIV;
            end else begin
               div_cmd = '{start: 1'b1, dividend: x_ff, divisor: y_ff};
               state_in = (state_ff == S_G1_DIV) ? S_G1_WAIT : S_G2_WAIT;
            end
         end
         S_G1_WAIT, S_G2_WAIT: begin
            if (div_rsp.done) begin
               x_in = y_ff;
               y_in = div_rsp.remainder;
               state_in = (state_ff == S_G1_WAIT) ? S_G1_DIV : S_G2_DIV;
            end
         end
         S_L_DIV: begin
            div_cmd = '{start: 1'b1, dividend: {32'd0, ad_ff}, divisor: x_ff};
            state_in = S_L_WAIT;
         end
         S_L_WAIT: if (div_rsp.done) begin
            q_in = div_rsp.quotient;
            state_in = S_L_MUL;
         end
         S_L_MUL: begin
            mul_a = q_ff[31:0]; mul_b = bd_ff;
            l_in = prod;
            state_in = S_TA_DIV;
         end
         S_TA_DIV: begin
            div_cmd = '{start: 1'b1, dividend: l_ff, divisor: {32'd0, ad_ff}};
            state_in = S_TA_WAIT;
         end
         S_TA_WAIT: if (div_rsp.done) begin
            q_in = div_rsp.quotient;
            state_in = S_TA_MUL;
         end
         S_TA_MUL: begin
            mul_a = q_ff[31:0]; mul_b = an_ff;
            ta_in = prod;
            state_in = S_TB_DIV;
         end
         S_TB_DIV: begin
            div_cmd = '{start: 1'b1, dividend: l_ff, divisor: {32'd0, bd_ff}};
            state_in = S_TB_WAIT;
         end
         S_TB_WAIT: if (div_rsp.done) begin
            q_in = div_rsp.quotient;
            state_in = S_TB_MUL;
         end
         S_TB_MUL: begin
            mul_a = q_ff[31:0]; mul_b = bn_ff;
            q_in = prod;   // hold tb
            state_in = S_COMBINE;
         end
         S_COMBINE: begin
            den_in = l_ff;
            if (aneg_ff == bneg_ff) begin
               num_in = ta_ff + q_ff; rneg_in = aneg_ff;
            end else if (ta_ff >= q_ff) begin
               num_in = ta_ff - q_ff; rneg_in = aneg_ff;
            end else begin
               num_in = q_ff - ta_ff; rneg_in = bneg_ff;
            end
            state_in = S_G2_DIV;
            x_in = num_in;
            y_in = l_ff;
         end
         S_MD_MUL1: begin
            mul_a = an_ff;
            mul_b = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
            num_in = prod;
            state_in = S_MD_MUL2;
         end
         S_MD_MUL2: begin
            mul_a = ad_ff;
            mul_b = (cmd_ff == CMD_MUL) ? bd_ff : bn_ff;
            den_in = prod;
            x_in = num_ff;
            y_in = prod;
            state_in = S_G2_DIV;
         end
         S_RN_DIV: begin
            div_cmd = '{start: 1'b1, dividend: num_ff, divisor: x_ff};
            state_in = S_RN_WAIT;
         end
         S_RN_WAIT: if (div_rsp.done) begin
            num_in = div_rsp.quotient;
            state_in = S_RD_DIV;
         end
         S_RD_DIV: begin
            div_cmd = '{start: 1'b1, dividend: den_ff, divisor: x_ff};
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: if (div_rsp.done) begin
            den_in = div_rsp.quotient;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
            if (den_ff[63] || (rneg_ff && num_ff != '0 ? num_ff > 64'h8000_0000_0000_0000
                  : num_ff[63])) begin
               rsp_in = '{result_num: '0, result_den: '0, status: ST_OVERFLOW};
            end else begin
               rsp_in.result_num = (rneg_ff && num_ff != '0) ? (64'd0 - num_ff) : num_ff;
               rsp_in.result_den = den_ff[62:0];
               rsp_in.status = ST_OK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      aneg_ff <= aneg_in; bneg_ff <= bneg_in; rneg_ff <= rneg_in;
      x_ff <= x_in; y_ff <= y_in;
      num_ff <= num_in; den_ff <= den_in;
      l_ff <= l_in; ta_ff <= ta_in; q_ff <= q_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data = rsp_ff;

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result shown twice");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy while showing result");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_OK) |-> rsp_data.result_den != '0)
      else $error("zero denominator with ok status");

endmodule
